>>> design/bcar_pkg.sv
package bcar_pkg;

   localparam int unsigned CELLS_DEFAULT        = 256;
   localparam int unsigned RULE_ENTRIES_DEFAULT = 128;
   localparam int unsigned MAX_RADIUS_DEFAULT   = 3;

   localparam int unsigned INDEX_WIDTH  = 8;
   localparam int unsigned RULE_WIDTH   = 64;
   localparam int unsigned RULE_SLOTS   = 128;
   localparam int unsigned RULE_SEL_W   = 7;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 64;

   localparam logic [1:0]            RADIUS_RESET    = 2'd1;
   localparam logic [RULE_WIDTH-1:0] RULE_LOW_RESET  = 64'd30;
   localparam logic [RULE_WIDTH-1:0] RULE_HIGH_RESET = 64'd0;

   typedef enum logic [1:0] {
      CMD_STEP  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_SEED  = 2'd3
   } cmd_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RADIUS    = 2'd0,
      CSR_RULE_LOW  = 2'd1,
      CSR_RULE_HIGH = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load_rsp;
   } ctl_cmd_type;

endpackage

>>> design/bcar_ctrl.sv
module bcar_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bcar_pkg::ctl_cmd_type ctl
);

   bcar_pkg::state_type state_ff;
   bcar_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bcar_pkg::ST_IDLE: begin
            if (req_valid) state_in = bcar_pkg::ST_EXEC;
         end
         bcar_pkg::ST_EXEC: begin
            state_in = bcar_pkg::ST_LOAD;
         end
         bcar_pkg::ST_LOAD: begin
            state_in = bcar_pkg::ST_RESP;
         end
         bcar_pkg::ST_RESP: begin
            if (!rsp_stall) state_in = bcar_pkg::ST_IDLE;
         end
         default: begin
            state_in = bcar_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      rsp_valid    = 1'b0;
      ctl.capture  = 1'b0;
      ctl.execute  = 1'b0;
      ctl.load_rsp = 1'b0;
      case (state_ff)
         bcar_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            ctl.capture = req_valid;
         end
         bcar_pkg::ST_EXEC: begin
            ctl.execute = 1'b1;
         end
         bcar_pkg::ST_LOAD: begin
            ctl.load_rsp = 1'b1;
         end
         bcar_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcar_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/bcar_datapath.sv
module bcar_datapath #(
   parameter int unsigned CELLS        = bcar_pkg::CELLS_DEFAULT,
   parameter int unsigned RULE_ENTRIES = bcar_pkg::RULE_ENTRIES_DEFAULT,
   parameter int unsigned MAX_RADIUS   = bcar_pkg::MAX_RADIUS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bcar_pkg::ctl_cmd_type             ctl,
   input  logic [1:0]                        req_command,
   input  logic [bcar_pkg::INDEX_WIDTH-1:0]  req_cell_index,
   input  logic                              req_cell_value,
   output logic                              rsp_cell_out,
   input  logic                              csr_write,
   input  logic [bcar_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bcar_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int unsigned AW     = $clog2(CELLS);
   localparam int unsigned NBW    = 2 * MAX_RADIUS + 1;
   localparam int unsigned CENTER = CELLS / 2;
   localparam int unsigned IW     = bcar_pkg::INDEX_WIDTH;
   localparam int unsigned RSW    = bcar_pkg::RULE_SEL_W;

   bcar_pkg::cmd_code_type cmd_ff, cmd_in;
   logic [AW-1:0]          addr_ff, addr_in;
   logic                   value_ff, value_in;
   logic [CELLS-1:0]       cells_ff, cells_in;
   logic [1:0]             radius_ff, radius_in;
   logic [bcar_pkg::RULE_WIDTH-1:0] rule_low_ff, rule_low_in;
   logic [bcar_pkg::RULE_WIDTH-1:0] rule_high_ff, rule_high_in;
   logic                   out_ff, out_in;

   logic [AW-1:0]                    addr_mod;
   logic [1:0]                       eff_radius;
   logic [bcar_pkg::RULE_SLOTS-1:0]  rule_tab;
   logic [CELLS-1:0]                 next_row;

   // cell index reduced into the ring
   if (CELLS < (1 << IW)) begin : g_mod
      logic [2*IW-1:0] rem;
      always_comb begin
         rem = {{IW{1'b0}}, req_cell_index};
         for (int k = IW - 1; k >= 0; k--) begin
            if (rem >= (2*IW)'(CELLS << k)) rem = rem - (2*IW)'(CELLS << k);
         end
         addr_mod = rem[AW-1:0];
      end
   end else begin : g_nomod
      assign addr_mod = AW'(req_cell_index);
   end

   always_comb begin
      if (radius_ff == 2'd0) begin
         eff_radius = 2'd1;
      end else if (radius_ff > 2'(MAX_RADIUS)) begin
         eff_radius = 2'(MAX_RADIUS);
      end else begin
         eff_radius = radius_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < bcar_pkg::RULE_SLOTS; i++) begin
         if (i >= RULE_ENTRIES) begin
            rule_tab[i] = 1'b0;
         end else if (i < bcar_pkg::RULE_WIDTH) begin
            rule_tab[i] = rule_low_ff[i];
         end else begin
            rule_tab[i] = rule_high_ff[i - bcar_pkg::RULE_WIDTH];
         end
      end
   end

   // one rule lookup per cell, leftmost neighbor is the msb
   for (genvar p = 0; p < CELLS; p++) begin : g_cell
      wire [MAX_RADIUS-1:0][NBW-1:0] win;
      logic [NBW-1:0]                sel;
      for (genvar rr = 1; rr <= MAX_RADIUS; rr++) begin : g_rad
         for (genvar b = 0; b < NBW; b++) begin : g_bit
            if (b <= 2 * rr) begin : g_tap
               assign win[rr-1][b] = cells_ff[(p + CELLS + rr - b) % CELLS];
            end else begin : g_zero
               assign win[rr-1][b] = 1'b0;
            end
         end
      end
      always_comb begin
         sel = '0;
         for (int r = 1; r <= MAX_RADIUS; r++) begin
            if (eff_radius == 2'(r)) sel = win[r-1];
         end
      end
      assign next_row[p] = rule_tab[RSW'(sel)];
   end

   always_comb begin
      cmd_in   = cmd_ff;
      addr_in  = addr_ff;
      value_in = value_ff;
      if (ctl.capture) begin
         cmd_in   = bcar_pkg::cmd_code_type'(req_command);
         addr_in  = addr_mod;
         value_in = req_cell_value;
      end
   end

   always_comb begin
      cells_in = cells_ff;
      if (ctl.execute) begin
         case (cmd_ff)
            bcar_pkg::CMD_STEP: begin
               cells_in = next_row;
            end
            bcar_pkg::CMD_WRITE: begin
               cells_in[addr_ff] = value_ff;
            end
            bcar_pkg::CMD_READ: begin
               cells_in = cells_ff;
            end
            bcar_pkg::CMD_SEED: begin
               cells_in         = '0;
               cells_in[CENTER] = 1'b1;
            end
            default: begin
               cells_in = cells_ff;
            end
         endcase
      end
   end

   assign out_in = ctl.load_rsp ? cells_ff[addr_ff] : out_ff;

   always_comb begin
      radius_in    = radius_ff;
      rule_low_in  = rule_low_ff;
      rule_high_in = rule_high_ff;
      if (csr_write) begin
         case (csr_index)
            bcar_pkg::CSR_RADIUS:    radius_in    = csr_data[1:0];
            bcar_pkg::CSR_RULE_LOW:  rule_low_in  = csr_data;
            bcar_pkg::CSR_RULE_HIGH: rule_high_in = csr_data;
            default: begin
               radius_in = radius_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff     <= '0;
         radius_ff    <= bcar_pkg::RADIUS_RESET;
         rule_low_ff  <= bcar_pkg::RULE_LOW_RESET;
         rule_high_ff <= bcar_pkg::RULE_HIGH_RESET;
      end else begin
         cells_ff     <= cells_in;
         radius_ff    <= radius_in;
         rule_low_ff  <= rule_low_in;
         rule_high_ff <= rule_high_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      addr_ff  <= addr_in;
      value_ff <= value_in;
      out_ff   <= out_in;
   end

   assign rsp_cell_out = out_ff;

endmodule

>>> design/binary_cellular_automaton_row.sv
// channel   direction  handshake          payload
// req_      in         req_valid/stall    req_command, req_cell_index, req_cell_value
// rsp_      out        rsp_valid/stall    rsp_cell_out
// csr_      in         csr_write          csr_index, csr_data
//
// an item goes through capture, execute, load result and present result
// a step updates the whole row in the execute cycle, one rule lookup per cell
// synchronous reset clears the row and loads the register reset values
// a stalled result holds; the next item is taken once the result is taken
module binary_cellular_automaton_row #(
   parameter int unsigned CELLS        = bcar_pkg::CELLS_DEFAULT,
   parameter int unsigned RULE_ENTRIES = bcar_pkg::RULE_ENTRIES_DEFAULT,
   parameter int unsigned MAX_RADIUS   = bcar_pkg::MAX_RADIUS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic [bcar_pkg::INDEX_WIDTH-1:0]  req_cell_index,
   input  logic                              req_cell_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_cell_out,
   input  logic                              csr_write,
   input  logic [bcar_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bcar_pkg::CSR_DATA_W-1:0]   csr_data
);

   bcar_pkg::ctl_cmd_type ctl;

   bcar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   bcar_datapath #(
      .CELLS        (CELLS),
      .RULE_ENTRIES (RULE_ENTRIES),
      .MAX_RADIUS   (MAX_RADIUS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .req_command    (req_command),
      .req_cell_index (req_cell_index),
      .req_cell_value (req_cell_value),
      .rsp_cell_out   (rsp_cell_out),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

endmodule
